FILE: design/dksl_pkg.sv
// ----------------------------------------------------------------------------
// dksl_pkg
// shared types and constants of the dual-key sorted sector list
// ----------------------------------------------------------------------------
`default_nettype none
package dksl_pkg;
  localparam int CAPACITY  = 32;
  localparam int TAG_BITS  = 8;
  localparam int CNT_BITS  = $clog2(CAPACITY + 1);
  localparam int SLOT_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int MAX_OUT   = 32;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_PRUNE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic signed [31:0]  right;
    logic [31:0]         distance;
    logic [SLOT_BITS-1:0] slot;
  } entry_t;

  // per-cycle control to every cell
  typedef struct packed {
    logic                insert;     // place new entry into this order
    logic                shift_out;  // shift toward head (pop)
    logic [SLOT_BITS-1:0] rm_slot;   // slot to be removed (distance order)
    logic                remove;     // remove rm_slot in place
    logic                step_read;  // rotate by one for read-out
    logic                key_dist;   // compare on distance, else right
  } cell_ctl_t;
endpackage
`default_nettype wire

FILE: design/dksl_cell.sv
// ----------------------------------------------------------------------------
// dksl_cell
// one position of a sorted order: holds an entry and trades with neighbors
// ----------------------------------------------------------------------------
`default_nettype none
module dksl_cell (
  input  wire logic            clk,
  input  wire dksl_pkg::cell_ctl_t ctl,
  input  wire dksl_pkg::entry_t new_e,
  input  wire logic            occ,        // this position holds an entry
  input  wire dksl_pkg::entry_t prev_e,
  input  wire logic            prev_go,    // predecessor goes after new entry
  input  wire logic            prev_rm,    // removal point at or before here
  input  wire dksl_pkg::entry_t next_e,
  output dksl_pkg::entry_t     e_o,
  output logic                 go_o,
  output logic                 rm_o
);
  import dksl_pkg::*;
  entry_t e_r, e_nxt;
  logic   here_go;

  always_comb begin
    if (ctl.key_dist) here_go = occ && (new_e.distance < e_r.distance);
    else              here_go = occ && (new_e.right < e_r.right);
    // empty positions count as after the new entry
    if (!occ) here_go = 1'b1;
    go_o = here_go;
    rm_o = prev_rm || (occ && (e_r.slot == ctl.rm_slot));
    e_nxt = e_r;
    if (ctl.insert) begin
      if (prev_go)      e_nxt = prev_e;
      else if (here_go) e_nxt = new_e;
    end else if (ctl.shift_out || ctl.step_read) begin
      e_nxt = next_e;
    end else if (ctl.remove && rm_o) begin
      e_nxt = next_e;
    end
  end

  always_ff @(posedge clk) begin
    e_r <= e_nxt;
  end
  assign e_o = e_r;
endmodule
`default_nettype wire

FILE: design/dksl_chain.sv
// ----------------------------------------------------------------------------
// dksl_chain
// a row of cells forming one sorted order
// ----------------------------------------------------------------------------
`default_nettype none
module dksl_chain (
  input  wire logic                   clk,
  input  wire dksl_pkg::cell_ctl_t    ctl,
  input  wire dksl_pkg::entry_t       new_e,
  input  wire logic [dksl_pkg::CNT_BITS-1:0] count,
  output dksl_pkg::entry_t            head_o
);
  import dksl_pkg::*;
  entry_t e   [CAPACITY];
  logic   go  [CAPACITY];
  logic   rm  [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t pe, ne;
    logic   pg, pr, oc;
    if (i == 0) begin : g_first
      assign pe = new_e;
      assign pg = 1'b0;
      assign pr = 1'b0;
    end else begin : g_mid
      assign pe = e[i-1];
      assign pg = go[i-1];
      assign pr = rm[i-1];
    end
    // during read-out the head wraps to the tail of the held entries
    if (i == CAPACITY - 1) begin : g_last
      assign ne = (ctl.step_read) ? e[0] : e[i];
    end else begin : g_inner
      assign ne = (ctl.step_read && (CNT_BITS'(i + 1) == count)) ? e[0] : e[i+1];
    end
    assign oc = CNT_BITS'(i) < count;
    dksl_cell u_cell (
      .clk(clk), .ctl(ctl), .new_e(new_e), .occ(oc),
      .prev_e(pe), .prev_go(pg), .prev_rm(pr), .next_e(ne),
      .e_o(e[i]), .go_o(go[i]), .rm_o(rm[i])
    );
  end
  assign head_o = e[0];
endmodule
`default_nettype wire

FILE: design/dual_key_sorted_sector_list.sv
// ----------------------------------------------------------------------------
// dual_key_sorted_sector_list
// tagged entries kept sorted by right coordinate and by distance
// ----------------------------------------------------------------------------
// usage: one command beat enters on the in_ channel (valid/stall). clear, add
// and prune each give one out_ beat with out_last high. read gives one beat per
// held entry in ascending distance, at most 32, last marked; an empty store
// gives a single zero beat.
// timing: add and clear pass through the exec and report states to the
// result register. a prune pops one entry at a time: pop from the right order,
// then compact the distance order. a read gives one beat a cycle while the
// receiver does not stall; the distance chain rotates one place per beat
// and is whole again after the last beat.
// reset: held count clears, store contents stay undefined and are never read
// before written. while out_stall is high the result register holds; a new
// command is accepted only in idle; the block takes one command at a time.
// ----------------------------------------------------------------------------
`default_nettype none
module dual_key_sorted_sector_list (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_command,
  input  wire logic [7:0]  in_sector_id,
  input  wire logic signed [31:0] in_right_coord,
  input  wire logic [31:0] in_distance,
  input  wire logic signed [31:0] in_threshold,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_status,
  output logic [7:0]       out_entry_id,
  output logic [31:0]      out_entry_distance,
  output logic             out_is_empty,
  output logic signed [31:0] out_least_right,
  output logic [5:0]       out_entry_count,
  output logic             out_last
);
  import dksl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_PRUNE, S_COMPACT, S_READ, S_REPORT
  } state_t;

  state_t               state_r;
  logic [CNT_BITS-1:0]  count_r;
  logic [CNT_BITS-1:0]  rd_idx_r;   // beats given so far in read-out
  logic [1:0]           cmd_r;
  entry_t               new_r;
  logic signed [31:0]   thr_r;
  logic                 status_r;
  logic [SLOT_BITS-1:0] rm_r;
  cell_ctl_t            rc, dc;
  entry_t               rhead, dhead;
  logic                 load_out;   // result register takes a new beat

  // slot numbers: with count entries, a fresh slot that is unique among the
  // held ones is needed; slot = count is not enough, as a prune can leave
  // held slots above count, so keep a free mask
  logic [CAPACITY-1:0]  used_r;
  logic [SLOT_BITS-1:0] free_slot;
  always_comb begin
    free_slot = '0;
    for (int i = CAPACITY - 1; i >= 0; i--)
      if (!used_r[i]) free_slot = SLOT_BITS'(i);
  end

  wire out_free = !out_valid || !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign load_out = out_free && ((state_r == S_READ) ||
                    (state_r == S_REPORT && cmd_r != CMD_READ));

  always_comb begin
    rc = '0; dc = '0;
    dc.key_dist = 1'b1;
    dc.rm_slot  = rm_r;
    case (state_r)
      S_EXEC: if (cmd_r == CMD_ADD && count_r < CNT_BITS'(CAPACITY)) begin
        rc.insert = 1'b1; dc.insert = 1'b1;
      end
      S_PRUNE: if (count_r != '0 && rhead.right <= thr_r) rc.shift_out = 1'b1;
      S_COMPACT: dc.remove = 1'b1;
      S_READ: if (out_free && count_r != '0) dc.step_read = 1'b1;
      S_REPORT: if (cmd_r == CMD_READ && rd_idx_r != count_r) dc.step_read = 1'b1;
      default: ;
    endcase
  end

  entry_t new_e;
  always_comb begin
    new_e = new_r;
    new_e.slot = free_slot;
  end

  dksl_chain u_right (.clk(clk), .ctl(rc), .new_e(new_e), .count(count_r), .head_o(rhead));
  dksl_chain u_dist  (.clk(clk), .ctl(dc), .new_e(new_e), .count(count_r), .head_o(dhead));

  logic [CNT_BITS-1:0] n_out;
  always_comb n_out = (count_r > CNT_BITS'(MAX_OUT)) ? CNT_BITS'(MAX_OUT) : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      used_r    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !load_out) out_valid <= 1'b0;
      case (state_r)
        S_IDLE: if (in_valid) begin
          cmd_r    <= in_command;
          new_r.tag   <= in_sector_id[TAG_BITS-1:0];
          new_r.right <= in_right_coord;
          new_r.distance <= in_distance;
          new_r.slot  <= '0;
          thr_r    <= in_threshold;
          status_r <= 1'b0;
          state_r  <= (in_command == CMD_PRUNE) ? S_PRUNE :
                      (in_command == CMD_READ) ? S_READ : S_EXEC;
          rd_idx_r <= '0;
        end
        S_EXEC: begin
          if (cmd_r == CMD_CLEAR) begin
            count_r <= '0; used_r <= '0;
          end else if (count_r < CNT_BITS'(CAPACITY)) begin
            count_r <= count_r + 1'b1;
            used_r[free_slot] <= 1'b1;
          end else status_r <= 1'b1;
          state_r <= S_REPORT;
        end
        S_PRUNE: begin
          if (rc.shift_out) begin
            rm_r <= rhead.slot;
            used_r[rhead.slot] <= 1'b0;
            state_r <= S_COMPACT;
          end else state_r <= S_REPORT;
        end
        S_COMPACT: begin
          count_r <= count_r - 1'b1;
          state_r <= S_PRUNE;
        end
        S_READ: if (out_free) begin
          out_valid    <= 1'b1;
          out_status   <= 1'b0;
          out_is_empty <= (count_r == '0);
          out_least_right <= (count_r == '0) ? 32'sd0 : rhead.right;
          out_entry_count <= 6'(count_r);
          if (count_r == '0) begin
            out_entry_id <= '0; out_entry_distance <= '0; out_last <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            out_entry_id <= 8'(dhead.tag);
            out_entry_distance <= dhead.distance;
            out_last <= (rd_idx_r + 1'b1 == n_out);
            rd_idx_r <= rd_idx_r + 1'b1;
            // rotate the remaining entries back so the order is whole again
            if (rd_idx_r + 1'b1 == n_out)
              state_r <= (n_out == count_r) ? S_IDLE : S_REPORT;
          end
        end
        S_REPORT: begin
          if (cmd_r == CMD_READ) begin
            // finish rotation for entries beyond the read-out window
            if (rd_idx_r == count_r) state_r <= S_IDLE;
            else rd_idx_r <= rd_idx_r + 1'b1;
          end else if (out_free) begin
            out_valid    <= 1'b1;
            out_status   <= status_r;
            out_entry_id <= '0;
            out_entry_distance <= '0;
            out_is_empty <= (count_r == '0);
            out_least_right <= (count_r == '0) ? 32'sd0 : rhead.right;
            out_entry_count <= 6'(count_r);
            out_last     <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // extra rotation step in report phase of a long read-out
  // (only with CAPACITY above the read-out limit)

  property p_no_accept_busy;
    @(posedge clk) disable iff (!rst_n) (state_r != S_IDLE) |-> in_stall;
  endproperty
  a_busy: assert property (p_no_accept_busy) else $error("accept while busy");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_BITS'(CAPACITY)) else $error("count over capacity");

  a_used: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ($countones(used_r) == int'(count_r)))
    else $error("slot mask disagrees with count");
endmodule
`default_nettype wire

FILE: verif/tb_dual_key_sorted_sector_list.sv
// ----------------------------------------------------------------------------
// tb_dual_key_sorted_sector_list
// self-checking bench: directed and random command beats, results compared
// beat by beat against an in-bench model of the two sorted orders
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_dual_key_sorted_sector_list;
  import dksl_pkg::*;

  typedef struct {
    cmd_t        cmd;
    logic [7:0]  id;
    logic signed [31:0] right;
    logic [31:0] distance;
    logic signed [31:0] thr;
  } cmd_beat_t;

  typedef struct {
    logic        status;
    logic [7:0]  id;
    logic [31:0] distance;
    logic        empty;
    logic signed [31:0] least;
    logic [5:0]  count;
    logic        last;
  } result_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_command = '0;
  logic [7:0] in_sector_id = '0;
  logic signed [31:0] in_right_coord = '0;
  logic [31:0] in_distance = '0;
  logic signed [31:0] in_threshold = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_status;
  logic [7:0] out_entry_id;
  logic [31:0] out_entry_distance;
  logic out_is_empty;
  logic signed [31:0] out_least_right;
  logic [5:0] out_entry_count;
  logic out_last;

  dual_key_sorted_sector_list DUT (.*);

  always #10 clk = ~clk;

  cmd_beat_t    pending_cmds[$];
  result_beat_t expected_results[$];
  int mismatches = 0;
  int send_idle_pct = 14;
  int recv_idle_pct = 86;
  bit hold_sender = 1'b0;

  // sorted store mirror: entries kept in arrays in insertion order, uids in sorted order
  logic [7:0]         st_tag[$];
  logic signed [31:0] st_right[$];
  logic [31:0]        st_dist[$];
  int                 st_uid[$];
  int                 by_right[$];  // uids ascending right
  int                 by_dist[$];   // uids ascending distance
  int                 next_uid = 0;

  function automatic int idx_of(int uid);
    foreach (st_uid[i]) if (st_uid[i] == uid) return i;
    return -1;
  endfunction

  function automatic result_beat_t status_beat(logic st, logic [7:0] id,
                                               logic [31:0] d, logic lst);
    result_beat_t r;
    r.status = st; r.id = id; r.distance = d; r.last = lst;
    r.empty = (by_right.size() == 0);
    r.least = r.empty ? 32'sd0 : st_right[idx_of(by_right[0])];
    r.count = 6'(by_right.size());
    return r;
  endfunction

  // apply one command to the mirror and queue its expected beats
  function automatic void predict_store(cmd_beat_t c);
    int pos, n, k;
    case (c.cmd)
      CMD_CLEAR: begin
        st_tag.delete(); st_right.delete(); st_dist.delete(); st_uid.delete();
        by_right.delete(); by_dist.delete();
        expected_results.push_back(status_beat(1'b0, 8'd0, 32'd0, 1'b1));
      end
      CMD_ADD: begin
        if (by_right.size() >= CAPACITY) begin
          expected_results.push_back(status_beat(1'b1, 8'd0, 32'd0, 1'b1));
        end else begin
          st_tag.push_back(c.id); st_right.push_back(c.right);
          st_dist.push_back(c.distance); st_uid.push_back(next_uid);
          // after equal keys in both orders
          pos = by_right.size();
          foreach (by_right[i]) if (c.right < st_right[idx_of(by_right[i])]) begin
            pos = i; break;
          end
          by_right.insert(pos, next_uid);
          pos = by_dist.size();
          foreach (by_dist[i]) if (c.distance < st_dist[idx_of(by_dist[i])]) begin
            pos = i; break;
          end
          by_dist.insert(pos, next_uid);
          next_uid++;
          expected_results.push_back(status_beat(1'b0, 8'd0, 32'd0, 1'b1));
        end
      end
      CMD_PRUNE: begin
        while (by_right.size() > 0 && st_right[idx_of(by_right[0])] <= c.thr) begin
          k = idx_of(by_right[0]);
          foreach (by_dist[i]) if (by_dist[i] == by_right[0]) begin
            by_dist.delete(i); break;
          end
          by_right.delete(0);
          st_tag.delete(k); st_right.delete(k); st_dist.delete(k); st_uid.delete(k);
        end
        expected_results.push_back(status_beat(1'b0, 8'd0, 32'd0, 1'b1));
      end
      default: begin
        n = by_dist.size();
        if (n == 0) expected_results.push_back(status_beat(1'b0, 8'd0, 32'd0, 1'b1));
        if (n > MAX_OUT) n = MAX_OUT;
        for (int j = 0; j < n; j++) begin
          k = idx_of(by_dist[j]);
          expected_results.push_back(status_beat(1'b0, st_tag[k], st_dist[k], j == n - 1));
        end
      end
    endcase
  endfunction

  // stall value seen at the last rising edge decides acceptance
  logic in_stall_q = 1'b1;
  always @(posedge clk) in_stall_q <= in_stall;

  // driver: changes inputs on the falling edge, predicts on acceptance
  bit accepted;
  always @(negedge clk) begin
    if (rst_n) begin
      accepted = in_valid && !in_stall_q;
      if (accepted) predict_store(pending_cmds.pop_front());
      if ((in_valid && !accepted) || pending_cmds.size() == 0 || hold_sender) begin
        if (!(in_valid && !accepted)) in_valid <= 1'b0;
      end else if ($urandom_range(99) < send_idle_pct) begin
        in_valid <= 1'b0;
      end else begin
        in_valid       <= 1'b1;
        in_command     <= pending_cmds[0].cmd;
        in_sector_id   <= pending_cmds[0].id;
        in_right_coord <= pending_cmds[0].right;
        in_distance    <= pending_cmds[0].distance;
        in_threshold   <= pending_cmds[0].thr;
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // monitor: compares each result beat with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat, id %0d", out_entry_id);
      end else begin
        result_beat_t e;
        e = expected_results.pop_front();
        if (out_status !== e.status || out_entry_id !== e.id ||
            out_entry_distance !== e.distance || out_is_empty !== e.empty ||
            out_least_right !== e.least || out_entry_count !== e.count ||
            out_last !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp st%0d id%0d d%h e%0d lr%h c%0d l%0d got st%0d id%0d d%h e%0d lr%h c%0d l%0d",
                     e.status, e.id, e.distance, e.empty, e.least, e.count, e.last,
                     out_status, out_entry_id, out_entry_distance, out_is_empty,
                     out_least_right, out_entry_count, out_last);
        end
      end
    end
  end

  function automatic cmd_beat_t mk(cmd_t c, logic [31:0] id, logic [31:0] r,
                                   logic [31:0] d, logic [31:0] t);
    cmd_beat_t b;
    b.cmd = c; b.id = id[7:0]; b.right = r; b.distance = d; b.thr = t;
    return b;
  endfunction

  // small key space so equal keys happen often
  function automatic logic [31:0] rand_key();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($urandom_range(7)) << 16;
      2: return {16'hFFFF, 16'($urandom_range(3))};
      default: return $urandom_range(2) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // sender held: wait for the beat on the wire and every result
  task automatic wait_results();
    while (in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  initial begin
    int r;
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed: empty read, extremes, equal keys, full store, prunes
    pending_cmds.push_back(mk(CMD_READ, 8'hFF, '1, '1, '1));
    pending_cmds.push_back(mk(CMD_PRUNE, 0, 0, 0, 32'h7FFF_FFFF));
    pending_cmds.push_back(mk(CMD_ADD, 8'hFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0));
    pending_cmds.push_back(mk(CMD_ADD, 8'h00, 32'h8000_0000, 32'h0, 0));
    pending_cmds.push_back(mk(CMD_ADD, 8'hA5, 32'h0001_0000, 32'h0001_0000, 0));
    pending_cmds.push_back(mk(CMD_ADD, 8'h5A, 32'h0001_0000, 32'h0001_0000, 0));
    pending_cmds.push_back(mk(CMD_READ, 0, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_PRUNE, 0, 0, 0, 32'h8000_0000));
    pending_cmds.push_back(mk(CMD_PRUNE, 0, 0, 0, 32'h0001_0000));
    pending_cmds.push_back(mk(CMD_READ, 0, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_CLEAR, '1, '1, '1, '1));
    for (int i = 0; i < 34; i++)
      pending_cmds.push_back(mk(CMD_ADD, i, rand_key(), rand_key(), 0));
    pending_cmds.push_back(mk(CMD_READ, 0, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_PRUNE, 0, 0, 0, 32'h7FFF_FFFF));
    pending_cmds.push_back(mk(CMD_READ, 0, 0, 0, 0));

    // random: mostly adds, with prunes, reads and some clears
    for (int phase = 0; phase < 3; phase++) begin
      for (int i = 0; i < 77; i++) begin
        r = $urandom_range(99);
        if (r < 55) pending_cmds.push_back(mk(CMD_ADD, $urandom, rand_key(), rand_key(), $urandom));
        else if (r < 75) pending_cmds.push_back(mk(CMD_PRUNE, $urandom, $urandom, $urandom, rand_key()));
        else if (r < 95) pending_cmds.push_back(mk(CMD_READ, $urandom, $urandom, $urandom, $urandom));
        else pending_cmds.push_back(mk(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom));
      end
      if (phase == 0) begin
        // sender holds until every result has arrived
        hold_sender = 1'b1;
        wait_results();
        hold_sender = 1'b0;
        wait_drained();
        send_idle_pct = 86; recv_idle_pct = 14;
      end else if (phase == 1) begin
        wait_drained();
        send_idle_pct = 0; recv_idle_pct = 0;
      end
    end
    wait_drained();
    if (mismatches == 0 && expected_results.size() == 0)
      $display("tb_dual_key_sorted_sector_list OK");
    else
      $display("tb_dual_key_sorted_sector_list NOT OK");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_dual_key_sorted_sector_list NOT OK");
    $finish;
  end
endmodule

FILE: sim.f
design/dksl_pkg.sv
design/dksl_cell.sv
design/dksl_chain.sv
design/dual_key_sorted_sector_list.sv
verif/tb_dual_key_sorted_sector_list.sv
